// ===== rtl/ilks_pkg.sv =====
`timescale 1ns / 1ps

package ilks_pkg;

  typedef struct packed {
    logic [2:0] mode;
    logic [3:0] msg_kind;
    logic [3:0] param_count;
    logic       first_is_channel;
    logic       first_is_debug_channel;
    logic       first_is_own_nick;
    logic       second_is_channel;
    logic       second_is_own_nick;
    logic       prefix_is_own_nick;
    logic [1:0] op_change;
    logic       seventh_is_here_op;
  } in_item_t;

  typedef struct packed {
    logic [4:0] action;
    logic       op_flag;
    logic       last;
  } out_item_t;

  localparam logic [2:0] MODE_CALL_BEGIN = 3'd0;
  localparam logic [2:0] MODE_MESSAGE    = 3'd1;
  localparam logic [2:0] MODE_CALL_END   = 3'd2;
  localparam logic [2:0] MODE_NET_READY  = 3'd3;
  localparam logic [2:0] MODE_NET_LOST   = 3'd4;

  localparam logic [3:0] MSG_WELCOME  = 4'd0;
  localparam logic [3:0] MSG_PING     = 4'd1;
  localparam logic [3:0] MSG_JOIN     = 4'd2;
  localparam logic [3:0] MSG_PONG     = 4'd3;
  localparam logic [3:0] MSG_PART     = 4'd4;
  localparam logic [3:0] MSG_KICK     = 4'd5;
  localparam logic [3:0] MSG_QUIT     = 4'd6;
  localparam logic [3:0] MSG_MODE     = 4'd7;
  localparam logic [3:0] MSG_PRIVMSG  = 4'd8;
  localparam logic [3:0] MSG_WHO      = 4'd9;
  localparam logic [3:0] MSG_NICK_IN_USE = 4'd10;
  localparam logic [3:0] MSG_TOPIC    = 4'd11;

  localparam logic [1:0] OPC_PLUS_O  = 2'd1;
  localparam logic [1:0] OPC_MINUS_O = 2'd2;

  localparam logic [4:0] ACT_PASS       = 5'd0;
  localparam logic [4:0] ACT_NICK       = 5'd1;
  localparam logic [4:0] ACT_USER       = 5'd2;
  localparam logic [4:0] ACT_JOIN_CHAN  = 5'd3;
  localparam logic [4:0] ACT_JOIN_DEBUG = 5'd4;
  localparam logic [4:0] ACT_WHO        = 5'd5;
  localparam logic [4:0] ACT_PING       = 5'd6;
  localparam logic [4:0] ACT_PONG       = 5'd7;
  localparam logic [4:0] ACT_USER_JOIN  = 5'd8;
  localparam logic [4:0] ACT_LEAVE_PFX  = 5'd9;
  localparam logic [4:0] ACT_LEAVE_PRM  = 5'd10;
  localparam logic [4:0] ACT_CHANOP     = 5'd11;
  localparam logic [4:0] ACT_MSG_CHAN   = 5'd12;
  localparam logic [4:0] ACT_MSG_QUERY  = 5'd13;
  localparam logic [4:0] ACT_WHO_ENTRY  = 5'd14;
  localparam logic [4:0] ACT_TOPIC      = 5'd15;
  localparam logic [4:0] ACT_APP_ENABLE = 5'd16;
  localparam logic [4:0] ACT_DISCONNECT = 5'd17;
  localparam logic [4:0] ACT_NEW_NICK   = 5'd18;
  localparam logic [4:0] ACT_NONE       = 5'd19;

  localparam logic [1:0] CFG_PING_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_DEBUG_ENABLE  = 2'd1;
  localparam logic [1:0] CFG_APP_ATTACHED  = 2'd2;

  localparam logic [15:0] PING_INTERVAL_RESET = 16'd60;
  localparam int unsigned LOGIN_WAIT = 10;
  localparam int unsigned JOIN_WAIT  = 30;

  typedef enum logic [11:0] {
    ST_DOWN         = 12'b0000_0000_0001,
    ST_LOGIN        = 12'b0000_0000_0010,
    ST_WAIT_USER    = 12'b0000_0000_0100,
    ST_NICK_RETRY   = 12'b0000_0000_1000,
    ST_WAIT_WELCOME = 12'b0000_0001_0000,
    ST_JOIN         = 12'b0000_0010_0000,
    ST_WAIT_JOIN    = 12'b0000_0100_0000,
    ST_JOIN_DEBUG   = 12'b0000_1000_0000,
    ST_WAIT_DEBUG   = 12'b0001_0000_0000,
    ST_WHO          = 12'b0010_0000_0000,
    ST_ONLINE       = 12'b0100_0000_0000,
    ST_WAIT_PONG    = 12'b1000_0000_0000
  } session_e;

endpackage

// ===== rtl/irc_login_keepalive_sequencer_core.sv =====
`timescale 1ns / 1ps

// IRC client session sequencer.
// The input channel carries one event per transfer: a call-begin tick, a
// classified received message, a call-end tick, or a network up/down event.
// Each event is decoded in the cycle it is accepted; it updates the session
// state and wait timer and pushes zero, one or two action codes into a
// four-entry result queue. The output channel presents the queue head, with
// last marking the final action of an event.
// Actions are written into the queue register before they reach the output.
// An event can be accepted every cycle while the queue has room for two
// actions, so throughput is set by the single output port, which passes
// on queued actions one at a time. When the receiver stalls, the queue
// fills and input ready drops until two entries are free again. The
// configuration channel is always ready; the user must write it only
// while idle, which the block itself does not enforce. Reset clears the
// queue, puts the session in the network-down state with a zero timer,
// and restores ping interval 60 with debug channel and application
// notifications disabled.

module irc_login_keepalive_sequencer_core #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ilks_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ilks_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_addr_i,
  input  logic [15:0]         cfg_data_i
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTRW  = $clog2(QDEPTH);
  localparam int unsigned QCNTW  = $clog2(QDEPTH + 1);
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam logic [TIMER_BITS-1:0] LOAD_LOGIN = TIMER_BITS'(ilks_pkg::LOGIN_WAIT);
  localparam logic [TIMER_BITS-1:0] LOAD_JOIN  = TIMER_BITS'(ilks_pkg::JOIN_WAIT);

  logic [15:0]            ping_q;
  logic                   dbg_en_q;
  logic                   app_q;
  ilks_pkg::session_e     state_q, state_d;
  logic [TIMER_BITS-1:0]  timer_q, timer_d;
  logic [TIMER_BITS-1:0]  ping_load;
  logic [32:0]            ping_ext;

  ilks_pkg::out_item_t    queue_q [QDEPTH];
  logic [QPTRW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [QCNTW-1:0]       count_q;

  ilks_pkg::out_item_t    res0, res1;
  logic [1:0]             n_res;
  logic                   in_fire, out_fire, expired;
  logic                   f_ch, f_dbg, f_own, s_ch, s_own, p_own;
  logic [3:0]             n_par;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (count_q <= QCNTW'(QDEPTH - 2));
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign out_data_o  = queue_q[rd_ptr_q];

  assign ping_ext  = 33'(ping_q);
  assign ping_load = (ping_ext > 33'(TIMER_MAX)) ? TIMER_MAX : TIMER_BITS'(ping_ext);
  assign expired   = (timer_q == '0);

  assign f_ch  = in_data_i.first_is_channel;
  assign f_dbg = in_data_i.first_is_debug_channel;
  assign f_own = in_data_i.first_is_own_nick;
  assign s_ch  = in_data_i.second_is_channel;
  assign s_own = in_data_i.second_is_own_nick;
  assign p_own = in_data_i.prefix_is_own_nick;
  assign n_par = in_data_i.param_count;

  always_comb begin
    state_d = state_q;
    timer_d = timer_q;
    n_res   = 2'd0;
    res0    = '{action: ilks_pkg::ACT_NONE, op_flag: 1'b0, last: 1'b0};
    res1    = '{action: ilks_pkg::ACT_NONE, op_flag: 1'b0, last: 1'b0};
    unique case (in_data_i.mode)
      ilks_pkg::MODE_CALL_BEGIN: begin
        if (!expired) begin
          timer_d = timer_q - TIMER_BITS'(1);
        end
      end
      ilks_pkg::MODE_MESSAGE: begin
        unique case (in_data_i.msg_kind)
          ilks_pkg::MSG_WELCOME: begin
            if (state_q == ilks_pkg::ST_WAIT_WELCOME) begin
              state_d = ilks_pkg::ST_JOIN;
            end
          end
          ilks_pkg::MSG_PING: begin
            res0.action = ilks_pkg::ACT_PONG;
            n_res = 2'd1;
          end
          ilks_pkg::MSG_JOIN: begin
            if (n_par >= 4'd1 && f_ch) begin
              if (p_own && state_q == ilks_pkg::ST_WAIT_JOIN) begin
                state_d = dbg_en_q ? ilks_pkg::ST_JOIN_DEBUG : ilks_pkg::ST_WHO;
              end else if (app_q) begin
                res0.action = ilks_pkg::ACT_USER_JOIN;
                n_res = 2'd1;
              end
            end
            if (n_par >= 4'd1 && dbg_en_q && f_dbg && p_own &&
                state_q == ilks_pkg::ST_WAIT_DEBUG) begin
              state_d = ilks_pkg::ST_WHO;
            end
          end
          ilks_pkg::MSG_PONG: begin
            if (state_q == ilks_pkg::ST_WAIT_PONG) begin
              timer_d = ping_load;
              state_d = ilks_pkg::ST_ONLINE;
            end
          end
          ilks_pkg::MSG_PART: begin
            if (n_par >= 4'd1 && f_ch && app_q) begin
              res0.action = ilks_pkg::ACT_LEAVE_PFX;
              n_res = 2'd1;
            end
          end
          ilks_pkg::MSG_KICK: begin
            if (n_par >= 4'd2 && f_ch) begin
              if (s_own) begin
                res0.action = ilks_pkg::ACT_DISCONNECT;
                n_res = 2'd1;
              end else if (app_q) begin
                res0.action = ilks_pkg::ACT_LEAVE_PRM;
                n_res = 2'd1;
              end
            end
          end
          ilks_pkg::MSG_QUIT: begin
            if (app_q) begin
              res0.action = ilks_pkg::ACT_LEAVE_PFX;
              n_res = 2'd1;
            end
          end
          ilks_pkg::MSG_MODE: begin
            if (n_par >= 4'd3 && f_ch && app_q) begin
              if (in_data_i.op_change == ilks_pkg::OPC_PLUS_O) begin
                res0.action  = ilks_pkg::ACT_CHANOP;
                res0.op_flag = 1'b1;
                n_res = 2'd1;
              end else if (in_data_i.op_change == ilks_pkg::OPC_MINUS_O) begin
                res0.action = ilks_pkg::ACT_CHANOP;
                n_res = 2'd1;
              end
            end
          end
          ilks_pkg::MSG_PRIVMSG: begin
            if (n_par == 4'd2 && app_q) begin
              if (f_ch) begin
                res0.action = ilks_pkg::ACT_MSG_CHAN;
                n_res = 2'd1;
              end else if (f_own) begin
                res0.action = ilks_pkg::ACT_MSG_QUERY;
                n_res = 2'd1;
              end
            end
          end
          ilks_pkg::MSG_WHO: begin
            if (n_par >= 4'd7 && f_own && s_ch && app_q) begin
              res0.action  = ilks_pkg::ACT_WHO_ENTRY;
              res0.op_flag = in_data_i.seventh_is_here_op;
              n_res = 2'd1;
            end
          end
          ilks_pkg::MSG_NICK_IN_USE: begin
            if (state_q == ilks_pkg::ST_WAIT_USER) begin
              state_d = ilks_pkg::ST_NICK_RETRY;
              timer_d = LOAD_LOGIN;
            end
          end
          ilks_pkg::MSG_TOPIC: begin
            if (n_par == 4'd2 && app_q && f_ch) begin
              res0.action = ilks_pkg::ACT_TOPIC;
              n_res = 2'd1;
            end
          end
          default: begin
          end
        endcase
      end
      ilks_pkg::MODE_CALL_END: begin
        unique case (state_q)
          ilks_pkg::ST_LOGIN: begin
            res0.action = ilks_pkg::ACT_PASS;
            res1.action = ilks_pkg::ACT_NICK;
            n_res   = 2'd2;
            timer_d = LOAD_LOGIN;
            state_d = ilks_pkg::ST_WAIT_USER;
          end
          ilks_pkg::ST_WAIT_USER: begin
            if (expired) begin
              res0.action = ilks_pkg::ACT_USER;
              n_res   = 2'd1;
              timer_d = LOAD_JOIN;
              state_d = ilks_pkg::ST_WAIT_WELCOME;
            end
          end
          ilks_pkg::ST_NICK_RETRY: begin
            if (expired) begin
              res0.action = ilks_pkg::ACT_NEW_NICK;
              res1.action = ilks_pkg::ACT_NICK;
              n_res   = 2'd2;
              timer_d = LOAD_LOGIN;
              state_d = ilks_pkg::ST_WAIT_USER;
            end
          end
          ilks_pkg::ST_WAIT_WELCOME, ilks_pkg::ST_WAIT_JOIN,
          ilks_pkg::ST_WAIT_DEBUG, ilks_pkg::ST_WAIT_PONG: begin
            if (expired) begin
              res0.action = ilks_pkg::ACT_DISCONNECT;
              n_res = 2'd1;
            end
          end
          ilks_pkg::ST_JOIN: begin
            res0.action = ilks_pkg::ACT_JOIN_CHAN;
            n_res   = 2'd1;
            timer_d = LOAD_JOIN;
            state_d = ilks_pkg::ST_WAIT_JOIN;
          end
          ilks_pkg::ST_JOIN_DEBUG: begin
            n_res = 2'd1;
            if (!dbg_en_q) begin
              res0.action = ilks_pkg::ACT_DISCONNECT;
            end else begin
              res0.action = ilks_pkg::ACT_JOIN_DEBUG;
              timer_d = LOAD_JOIN;
              state_d = ilks_pkg::ST_WAIT_DEBUG;
            end
          end
          ilks_pkg::ST_WHO: begin
            res0.action = ilks_pkg::ACT_WHO;
            res1.action = ilks_pkg::ACT_APP_ENABLE;
            n_res   = app_q ? 2'd2 : 2'd1;
            timer_d = ping_load;
            state_d = ilks_pkg::ST_ONLINE;
          end
          ilks_pkg::ST_ONLINE: begin
            if (expired) begin
              res0.action = ilks_pkg::ACT_PING;
              n_res   = 2'd1;
              timer_d = ping_load;
              state_d = ilks_pkg::ST_WAIT_PONG;
            end
          end
          default: begin
          end
        endcase
      end
      ilks_pkg::MODE_NET_READY: begin
        state_d = ilks_pkg::ST_LOGIN;
        res0.action = ilks_pkg::ACT_NEW_NICK;
        n_res = 2'd1;
      end
      ilks_pkg::MODE_NET_LOST: begin
        state_d = ilks_pkg::ST_DOWN;
      end
      default: begin
      end
    endcase
    res0.last = (n_res == 2'd1);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ping_q   <= ilks_pkg::PING_INTERVAL_RESET;
      dbg_en_q <= 1'b0;
      app_q    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        ilks_pkg::CFG_PING_INTERVAL: ping_q   <= cfg_data_i;
        ilks_pkg::CFG_DEBUG_ENABLE:  dbg_en_q <= cfg_data_i[0];
        ilks_pkg::CFG_APP_ATTACHED:  app_q    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ilks_pkg::ST_DOWN;
      timer_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
      timer_q <= timer_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && n_res != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (in_fire && n_res == 2'd2) begin
      queue_q[wr_ptr_q + QPTRW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + QPTRW'(n_res);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + QPTRW'(1);
      end
      count_q <= count_q + (in_fire ? QCNTW'(n_res) : '0) - QCNTW'(out_fire);
    end
  end

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNTW'(QDEPTH))
    else $error("result queue count exceeds its depth");

  a_net_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.mode == ilks_pkg::MODE_NET_LOST |=> state_q == ilks_pkg::ST_DOWN)
    else $error("network lost did not return the session to down");

  a_net_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.mode == ilks_pkg::MODE_NET_READY && count_q == '0
    |=> out_valid_o && out_data_o.action == ilks_pkg::ACT_NEW_NICK && out_data_o.last)
    else $error("network ready did not present a new nick action");

  a_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.mode == ilks_pkg::MODE_CALL_BEGIN && timer_q != '0
    |=> timer_q == $past(timer_q) - TIMER_BITS'(1))
    else $error("call begin tick did not count the wait timer down");

endmodule

// ===== tb/sv/tb_irc_login_keepalive_sequencer_core.sv =====
`timescale 1ns / 1ps

module tb_irc_login_keepalive_sequencer_core;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SEGMENT_EVENTS = 292;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [3:0] MSG_OTHER = 4'd12;
  localparam logic [3:0] MSG_RESERVED = 4'd15;
  localparam logic [1:0] OPC_UNUSED = 2'd3;

  typedef enum logic [3:0] {
    SS_DOWN         = 4'd0,
    SS_LOGIN        = 4'd1,
    SS_WAIT_USER    = 4'd2,
    SS_NICK_RETRY   = 4'd3,
    SS_WAIT_WELCOME = 4'd4,
    SS_JOIN         = 4'd5,
    SS_WAIT_JOIN    = 4'd6,
    SS_JOIN_DEBUG   = 4'd7,
    SS_WAIT_DEBUG   = 4'd8,
    SS_WHO          = 4'd10,
    SS_ONLINE       = 4'd11,
    SS_WAIT_PONG    = 4'd12
  } sess_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ilks_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ilks_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_addr = '0;
  logic [15:0]         cfg_data = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned err_count = 0;

  logic [15:0]         ping_interval_q;
  logic                debug_enable_q;
  logic                app_attached_q;
  sess_e               session_q;
  logic [15:0]         wait_timer_q;
  logic                disconnect_requested;
  ilks_pkg::out_item_t step_acts [2];
  logic [1:0]          step_count;
  ilks_pkg::out_item_t expected_actions [$];

  irc_login_keepalive_sequencer_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_addr_i  (cfg_addr),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_irc_login_keepalive_sequencer_core: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      err_count++;
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_actions
    ilks_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_actions.size() == 0) begin
        err_count++;
        $error("action %0d transferred with none pending", out_data.action);
      end else begin
        want = expected_actions.pop_front();
        check_field("action", 32'(want.action), 32'(out_data.action));
        check_field("op_flag", 32'(want.op_flag), 32'(out_data.op_flag));
        check_field("last", 32'(want.last), 32'(out_data.last));
      end
    end
  end

  function automatic void reset_session_model();
    ping_interval_q = ilks_pkg::PING_INTERVAL_RESET;
    debug_enable_q = 1'b0;
    app_attached_q = 1'b0;
    session_q = SS_DOWN;
    wait_timer_q = '0;
    disconnect_requested = 1'b0;
  endfunction

  function automatic void post_action(logic [4:0] act, logic op);
    if (step_count < 2'd2) begin
      step_acts[step_count[0]].action = act;
      step_acts[step_count[0]].op_flag = op;
      step_acts[step_count[0]].last = 1'b0;
      step_count++;
    end
  endfunction

  function automatic void session_on_message(ilks_pkg::in_item_t it);
    case (it.msg_kind)
      ilks_pkg::MSG_WELCOME: begin
        if (session_q == SS_WAIT_WELCOME) session_q = SS_JOIN;
      end
      ilks_pkg::MSG_PING: begin
        post_action(ilks_pkg::ACT_PONG, 1'b0);
      end
      ilks_pkg::MSG_JOIN: begin
        if (it.param_count >= 1 && it.first_is_channel) begin
          if (it.prefix_is_own_nick && session_q == SS_WAIT_JOIN) begin
            session_q = debug_enable_q ? SS_JOIN_DEBUG : SS_WHO;
          end else if (app_attached_q) begin
            post_action(ilks_pkg::ACT_USER_JOIN, 1'b0);
          end
        end
        if (it.param_count >= 1 && debug_enable_q && it.first_is_debug_channel &&
            it.prefix_is_own_nick && session_q == SS_WAIT_DEBUG) begin
          session_q = SS_WHO;
        end
      end
      ilks_pkg::MSG_PONG: begin
        if (session_q == SS_WAIT_PONG) begin
          wait_timer_q = ping_interval_q;
          session_q = SS_ONLINE;
        end
      end
      ilks_pkg::MSG_PART: begin
        if (it.param_count >= 1 && it.first_is_channel && app_attached_q) begin
          post_action(ilks_pkg::ACT_LEAVE_PFX, 1'b0);
        end
      end
      ilks_pkg::MSG_KICK: begin
        if (it.param_count >= 2 && it.first_is_channel) begin
          if (it.second_is_own_nick) begin
            post_action(ilks_pkg::ACT_DISCONNECT, 1'b0);
          end else if (app_attached_q) begin
            post_action(ilks_pkg::ACT_LEAVE_PRM, 1'b0);
          end
        end
      end
      ilks_pkg::MSG_QUIT: begin
        if (app_attached_q) post_action(ilks_pkg::ACT_LEAVE_PFX, 1'b0);
      end
      ilks_pkg::MSG_MODE: begin
        if (it.param_count >= 3 && it.first_is_channel && app_attached_q) begin
          if (it.op_change == ilks_pkg::OPC_PLUS_O) begin
            post_action(ilks_pkg::ACT_CHANOP, 1'b1);
          end else if (it.op_change == ilks_pkg::OPC_MINUS_O) begin
            post_action(ilks_pkg::ACT_CHANOP, 1'b0);
          end
        end
      end
      ilks_pkg::MSG_PRIVMSG: begin
        if (it.param_count == 2 && app_attached_q) begin
          if (it.first_is_channel) begin
            post_action(ilks_pkg::ACT_MSG_CHAN, 1'b0);
          end else if (it.first_is_own_nick) begin
            post_action(ilks_pkg::ACT_MSG_QUERY, 1'b0);
          end
        end
      end
      ilks_pkg::MSG_WHO: begin
        if (it.param_count >= 7 && it.first_is_own_nick && it.second_is_channel &&
            app_attached_q) begin
          post_action(ilks_pkg::ACT_WHO_ENTRY, it.seventh_is_here_op);
        end
      end
      ilks_pkg::MSG_NICK_IN_USE: begin
        if (session_q == SS_WAIT_USER) begin
          session_q = SS_NICK_RETRY;
          wait_timer_q = 16'(ilks_pkg::LOGIN_WAIT);
        end
      end
      ilks_pkg::MSG_TOPIC: begin
        if (it.param_count == 2 && app_attached_q && it.first_is_channel) begin
          post_action(ilks_pkg::ACT_TOPIC, 1'b0);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void session_on_call_end();
    logic expired;
    expired = (wait_timer_q == '0);
    case (session_q)
      SS_LOGIN: begin
        post_action(ilks_pkg::ACT_PASS, 1'b0);
        post_action(ilks_pkg::ACT_NICK, 1'b0);
        wait_timer_q = 16'(ilks_pkg::LOGIN_WAIT);
        session_q = SS_WAIT_USER;
      end
      SS_WAIT_USER: begin
        if (expired) begin
          post_action(ilks_pkg::ACT_USER, 1'b0);
          wait_timer_q = 16'(ilks_pkg::JOIN_WAIT);
          session_q = SS_WAIT_WELCOME;
        end
      end
      SS_NICK_RETRY: begin
        if (expired) begin
          post_action(ilks_pkg::ACT_NEW_NICK, 1'b0);
          post_action(ilks_pkg::ACT_NICK, 1'b0);
          wait_timer_q = 16'(ilks_pkg::LOGIN_WAIT);
          session_q = SS_WAIT_USER;
        end
      end
      SS_WAIT_WELCOME, SS_WAIT_JOIN, SS_WAIT_DEBUG, SS_WAIT_PONG: begin
        if (expired) post_action(ilks_pkg::ACT_DISCONNECT, 1'b0);
      end
      SS_JOIN: begin
        post_action(ilks_pkg::ACT_JOIN_CHAN, 1'b0);
        wait_timer_q = 16'(ilks_pkg::JOIN_WAIT);
        session_q = SS_WAIT_JOIN;
      end
      SS_JOIN_DEBUG: begin
        if (!debug_enable_q) begin
          post_action(ilks_pkg::ACT_DISCONNECT, 1'b0);
        end else begin
          post_action(ilks_pkg::ACT_JOIN_DEBUG, 1'b0);
          wait_timer_q = 16'(ilks_pkg::JOIN_WAIT);
          session_q = SS_WAIT_DEBUG;
        end
      end
      SS_WHO: begin
        post_action(ilks_pkg::ACT_WHO, 1'b0);
        wait_timer_q = ping_interval_q;
        session_q = SS_ONLINE;
        if (app_attached_q) post_action(ilks_pkg::ACT_APP_ENABLE, 1'b0);
      end
      SS_ONLINE: begin
        if (expired) begin
          post_action(ilks_pkg::ACT_PING, 1'b0);
          wait_timer_q = ping_interval_q;
          session_q = SS_WAIT_PONG;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_session_actions(ilks_pkg::in_item_t it);
    step_count = 2'd0;
    case (it.mode)
      ilks_pkg::MODE_CALL_BEGIN: begin
        if (wait_timer_q != '0) wait_timer_q = wait_timer_q - 16'd1;
      end
      ilks_pkg::MODE_MESSAGE: session_on_message(it);
      ilks_pkg::MODE_CALL_END: session_on_call_end();
      ilks_pkg::MODE_NET_READY: begin
        session_q = SS_LOGIN;
        disconnect_requested = 1'b0;
        post_action(ilks_pkg::ACT_NEW_NICK, 1'b0);
      end
      ilks_pkg::MODE_NET_LOST: begin
        session_q = SS_DOWN;
        disconnect_requested = 1'b0;
      end
      default: ;
    endcase
    for (logic [1:0] k = 2'd0; k < step_count; k++) begin
      if (k == step_count - 2'd1) step_acts[k[0]].last = 1'b1;
      if (step_acts[k[0]].action == ilks_pkg::ACT_DISCONNECT) disconnect_requested = 1'b1;
      expected_actions.push_back(step_acts[k[0]]);
    end
  endfunction

  task automatic send_event(ilks_pkg::in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_session_actions(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_actions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ilks_pkg::CFG_PING_INTERVAL: ping_interval_q = value;
      ilks_pkg::CFG_DEBUG_ENABLE: debug_enable_q = value[0];
      ilks_pkg::CFG_APP_ATTACHED: app_attached_q = value[0];
      default: ;
    endcase
  endtask

  // The one-bit registers get random upper data bits, which must be ignored.
  task automatic configure(logic [15:0] ping, logic dbg, logic app);
    logic [15:0] noise;
    wait_idle();
    write_reg(ilks_pkg::CFG_PING_INTERVAL, ping);
    noise = 16'($urandom);
    write_reg(ilks_pkg::CFG_DEBUG_ENABLE, {noise[15:1], dbg});
    noise = 16'($urandom);
    write_reg(ilks_pkg::CFG_APP_ATTACHED, {noise[15:1], app});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic ilks_pkg::in_item_t base_event(logic [2:0] m);
    ilks_pkg::in_item_t it;
    it = '0;
    it.mode = m;
    return it;
  endfunction

  function automatic ilks_pkg::in_item_t message(logic [3:0] kind, logic [3:0] n);
    ilks_pkg::in_item_t it;
    it = base_event(ilks_pkg::MODE_MESSAGE);
    it.msg_kind = kind;
    it.param_count = n;
    return it;
  endfunction

  function automatic ilks_pkg::in_item_t random_message(logic [3:0] kind);
    ilks_pkg::in_item_t it;
    logic [19:0] raw;
    raw = 20'($urandom);
    it = raw;
    it.mode = ilks_pkg::MODE_MESSAGE;
    it.msg_kind = kind;
    if ($urandom_range(1) == 1) begin
      case ($urandom_range(3))
        0: it.param_count = 4'd1;
        1: it.param_count = 4'd2;
        2: it.param_count = 4'd3;
        default: it.param_count = 4'd7;
      endcase
    end
    return it;
  endfunction

  function automatic ilks_pkg::in_item_t tick_event();
    if (wait_timer_q != '0 && $urandom_range(7) != 0) begin
      return base_event(ilks_pkg::MODE_CALL_BEGIN);
    end
    return base_event(ilks_pkg::MODE_CALL_END);
  endfunction

  // Mostly steps that move the session forward, with some raw noise mixed in.
  function automatic ilks_pkg::in_item_t next_event();
    ilks_pkg::in_item_t it;
    logic [19:0]        raw;
    int unsigned        roll;
    roll = $urandom_range(99);
    if (roll < 10) begin
      raw = 20'($urandom);
      it = raw;
      if ((it.mode == ilks_pkg::MODE_NET_READY || it.mode == ilks_pkg::MODE_NET_LOST) &&
          $urandom_range(3) != 0) begin
        it.mode = ilks_pkg::MODE_MESSAGE;
      end
      return it;
    end
    if (disconnect_requested && roll < 90) return base_event(ilks_pkg::MODE_NET_LOST);
    case (session_q)
      SS_DOWN: it = base_event(ilks_pkg::MODE_NET_READY);
      SS_WAIT_USER: begin
        it = (roll < 16) ? random_message(ilks_pkg::MSG_NICK_IN_USE) : tick_event();
      end
      SS_WAIT_WELCOME: begin
        it = (roll < 40) ? random_message(ilks_pkg::MSG_WELCOME) : tick_event();
      end
      SS_WAIT_JOIN, SS_WAIT_DEBUG: begin
        if (roll < 50) begin
          it = random_message(ilks_pkg::MSG_JOIN);
          if (it.param_count == '0) it.param_count = 4'd1;
          it.prefix_is_own_nick = 1'b1;
          if (session_q == SS_WAIT_JOIN) begin
            it.first_is_channel = (roll < 40);
          end else begin
            it.first_is_debug_channel = (roll < 40);
          end
        end else begin
          it = tick_event();
        end
      end
      SS_ONLINE, SS_WAIT_PONG: begin
        if (roll < 25 && session_q == SS_WAIT_PONG) begin
          it = random_message(ilks_pkg::MSG_PONG);
        end else if (roll < 55) begin
          it = random_message(4'($urandom_range(0, 11)));
        end else begin
          it = tick_event();
        end
      end
      default: it = tick_event();
    endcase
    return it;
  endfunction

  task automatic test_reset_defaults();
    send_event(base_event(ilks_pkg::MODE_CALL_END));
    send_event(base_event(ilks_pkg::MODE_NET_READY));
    send_event(message(ilks_pkg::MSG_QUIT, 4'd1));
    send_event(message(ilks_pkg::MSG_PING, 4'd0));
    send_event(base_event(ilks_pkg::MODE_NET_LOST));
  endtask

  task automatic test_notifications();
    ilks_pkg::in_item_t it;
    configure(ilks_pkg::PING_INTERVAL_RESET, 1'b0, 1'b1);
    send_event(message(ilks_pkg::MSG_PING, 4'd15));
    it = message(ilks_pkg::MSG_JOIN, 4'd1);
    it.first_is_channel = 1'b1;
    send_event(it);
    it = message(ilks_pkg::MSG_PART, 4'd1);
    it.first_is_channel = 1'b1;
    send_event(it);
    it = message(ilks_pkg::MSG_KICK, 4'd2);
    it.first_is_channel = 1'b1;
    it.second_is_own_nick = 1'b1;
    send_event(it);
    it.second_is_own_nick = 1'b0;
    send_event(it);
    it = message(ilks_pkg::MSG_MODE, 4'd3);
    it.first_is_channel = 1'b1;
    it.op_change = ilks_pkg::OPC_PLUS_O;
    send_event(it);
    it.op_change = ilks_pkg::OPC_MINUS_O;
    send_event(it);
    it.op_change = OPC_UNUSED;
    send_event(it);
    it = message(ilks_pkg::MSG_PRIVMSG, 4'd2);
    it.first_is_channel = 1'b1;
    send_event(it);
    it.first_is_channel = 1'b0;
    it.first_is_own_nick = 1'b1;
    send_event(it);
    it = message(ilks_pkg::MSG_WHO, 4'd7);
    it.first_is_own_nick = 1'b1;
    it.second_is_channel = 1'b1;
    it.seventh_is_here_op = 1'b1;
    send_event(it);
    it.param_count = 4'd15;
    it.seventh_is_here_op = 1'b0;
    send_event(it);
    it = message(ilks_pkg::MSG_TOPIC, 4'd2);
    it.first_is_channel = 1'b1;
    send_event(it);
    send_event(message(MSG_OTHER, 4'd2));
    send_event(message(MSG_RESERVED, 4'd15));
    it = '1;
    send_event(it);
  endtask

  // A zero ping interval makes every call end in the keepalive states act at once.
  task automatic test_keepalive();
    ilks_pkg::in_item_t it;
    configure(16'd0, 1'b1, 1'b1);
    send_event(base_event(ilks_pkg::MODE_NET_READY));
    send_event(base_event(ilks_pkg::MODE_CALL_END));
    send_event(base_event(ilks_pkg::MODE_CALL_END));
    repeat (ilks_pkg::LOGIN_WAIT + 1) send_event(base_event(ilks_pkg::MODE_CALL_BEGIN));
    send_event(base_event(ilks_pkg::MODE_CALL_END));
    send_event(message(ilks_pkg::MSG_WELCOME, 4'd1));
    send_event(base_event(ilks_pkg::MODE_CALL_END));
    it = message(ilks_pkg::MSG_JOIN, 4'd1);
    it.first_is_channel = 1'b1;
    it.prefix_is_own_nick = 1'b1;
    send_event(it);
    configure(16'd0, 1'b0, 1'b1);
    send_event(base_event(ilks_pkg::MODE_CALL_END));
    configure(16'd0, 1'b1, 1'b1);
    send_event(base_event(ilks_pkg::MODE_CALL_END));
    it = message(ilks_pkg::MSG_JOIN, 4'd1);
    it.first_is_debug_channel = 1'b1;
    it.prefix_is_own_nick = 1'b1;
    send_event(it);
    send_event(base_event(ilks_pkg::MODE_CALL_END));
    send_event(base_event(ilks_pkg::MODE_CALL_END));
    send_event(base_event(ilks_pkg::MODE_CALL_END));
    send_event(message(ilks_pkg::MSG_PONG, 4'd1));
    send_event(base_event(ilks_pkg::MODE_NET_LOST));
  endtask

  task automatic test_random_sessions();
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: configure(16'd1, 1'b1, 1'b1);
        1: configure(16'hFFFF, 1'b0, 1'b0);
        2: configure(16'($urandom_range(2, 12)), 1'b1, 1'b0);
        3: configure(16'($urandom_range(1, 8)), 1'b0, 1'b1);
        4: configure(16'($urandom_range(1, 20)), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
        default: configure(16'd3, 1'b1, 1'b1);
      endcase
      if (seg < 2) begin
        send_idle_pct = 7;
        recv_stall_pct = 56;
      end else if (seg < 4) begin
        send_idle_pct = 56;
        recv_stall_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      repeat (SEGMENT_EVENTS) send_event(next_event());
    end
  endtask

  initial begin
    reset_session_model();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 7;
    recv_stall_pct = 56;
    test_reset_defaults();
    test_notifications();
    test_keepalive();
    test_random_sessions();
    wait_idle();
    repeat (16) @(posedge clk);
    if (err_count == 0 && expected_actions.size() == 0) begin
      $display("tb_irc_login_keepalive_sequencer_core: clean");
    end else begin
      $display("tb_irc_login_keepalive_sequencer_core: errors");
    end
    $finish;
  end

endmodule
